### hw/rtl/rtsm_pkg.sv
// Package for the rover throttle and steering mixer.
// A shared constant and the sequencer handshake struct; no dependencies.
`default_nettype none
package rtsm_pkg;
  localparam int unsigned Q8Full = 25600;

  typedef struct packed {
    logic start;
    logic busy;
  } seq_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/rtsm_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Uses rtsm_pkg for the start and busy handshake struct.
`default_nettype none
module rtsm_divider #(
  parameter int unsigned W = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rtsm_pkg::seq_ctl_t ctl,
  input  wire logic [W-1:0]     num,
  input  wire logic [W-1:0]     den,
  output logic                  done,
  output logic [W-1:0]          quo
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  q_r, d_r;
  logic [W:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic [W:0]    trial;

  assign trial = {rem_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
  assign quo   = q_r;
  assign done  = run_r && (cnt_r == CW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.start) begin
      run_r <= 1'b1;
      cnt_r <= CW'(W);
      q_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (run_r) begin
      if (cnt_r == CW'(0)) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CW'(1);
        if (!trial[W]) begin
          rem_r <= trial;
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-1:0], q_r[W-1]};
          q_r   <= {q_r[W-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/rtsm_sqrt.sv
// Integer square root, one result bit per cycle (two radicand bits).
// Uses rtsm_pkg for the start and busy handshake struct.
`default_nettype none
module rtsm_sqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rtsm_pkg::seq_ctl_t ctl,
  input  wire logic [47:0]        rad,
  output logic                    done,
  output logic [23:0]             root
);
  logic [47:0] x_r;
  logic [25:0] rem_r;
  logic [23:0] r_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [25:0] cand, trial;

  assign cand  = {rem_r[23:0], x_r[47:46]};
  assign trial = cand - {r_r, 2'b01};
  assign root  = r_r;
  assign done  = run_r && (cnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.start) begin
      run_r <= 1'b1;
      cnt_r <= 5'd24;
      x_r   <= rad;
      rem_r <= '0;
      r_r   <= '0;
    end else if (run_r) begin
      if (cnt_r == 5'd0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
        x_r   <= {x_r[45:0], 2'b00};
        if (!trial[25]) begin
          rem_r <= trial;
          r_r   <= {r_r[22:0], 1'b1};
        end else begin
          rem_r <= cand;
          r_r   <= {r_r[22:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/rover_throttle_steer_mixer.sv
// Rover throttle and steering output mixer, top level.
// A beat makes up to four passes through the shared bit-serial divider and one pass of the
// square root unit when every stage runs; a disarmed beat with the slew limit off uses neither.
// One beat is worked at a time; the result sits in an output register and the
// next input beat is taken the cycle after that register is emptied.
// Reset (rst_n low, synchronous) restores register defaults and clears history.
`default_nettype none
module rover_throttle_steer_mixer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: throttle_in[15:0], steer_in[29:16], speed[45:30], elapsed_ms[55:46],
  // now_ms[87:56], zero fill to 96 bits
  input  wire logic [95:0] in_tdata,
  // tuser: armed
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: throttle_out[15:0], steer_out[29:16], zero fill to 32 bits
  output logic [31:0]      out_tdata,
  // tuser: throttle_zero_pwm, limit_steer_left, limit_steer_right,
  // limit_throttle_lower, limit_throttle_upper (lowest bit first)
  output logic [4:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [2:0] RegTmin = 3'd0, RegExpo = 3'd1, RegBase = 3'd2, RegSmax = 3'd3,
                         RegTmax = 3'd4, RegSlew = 3'd5, RegRdly = 3'd6, RegScal = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_SLEW, S_STEER, S_MIN, S_MINW, S_RAD, S_SQRT, S_CDIV, S_CDIVW,
    S_HOLD, S_OUT
  } state_t;

  // Configuration registers.
  logic [14:0] tmin_r, base_r, tmax_r;
  logic signed [9:0] expo_r;
  logic [12:0] smax_r;
  logic [9:0]  slew_r;
  logic [13:0] rdly_r;
  logic        scal_r;

  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[4:2])
      RegTmin: cfg_prdata = {17'd0, tmin_r};
      RegExpo: cfg_prdata = {{22{expo_r[9]}}, expo_r};
      RegBase: cfg_prdata = {17'd0, base_r};
      RegSmax: cfg_prdata = {19'd0, smax_r};
      RegTmax: cfg_prdata = {17'd0, tmax_r};
      RegSlew: cfg_prdata = {22'd0, slew_r};
      RegRdly: cfg_prdata = {18'd0, rdly_r};
      default: cfg_prdata = {31'd0, scal_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmin_r <= '0; expo_r <= '0; base_r <= '0; smax_r <= 13'd4500;
      tmax_r <= 15'd25600; slew_r <= '0; rdly_r <= '0; scal_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[4:2])
        RegTmin: tmin_r <= cfg_pwdata[14:0];
        RegExpo: expo_r <= cfg_pwdata[9:0];
        RegBase: base_r <= cfg_pwdata[14:0];
        RegSmax: smax_r <= cfg_pwdata[12:0];
        RegTmax: tmax_r <= cfg_pwdata[14:0];
        RegSlew: slew_r <= cfg_pwdata[9:0];
        RegRdly: rdly_r <= cfg_pwdata[13:0];
        default: scal_r <= cfg_pwdata[0];
      endcase
    end
  end

  // Working registers.
  state_t state_r;
  logic armed_r;
  logic signed [15:0] thr_in_r, speed_r;
  logic signed [13:0] steer_r;
  logic [9:0]  dt_r;
  logic [31:0] now_r;
  logic signed [16:0] thr_r;      // slew-limited throttle
  logic signed [16:0] prev_r, lnz_r;
  logic [31:0] lot_r;
  logic [15:0] mag_r;
  logic        neg_r;
  logic signed [47:0] acc_r;      // curve numerator work value
  logic        cneg_r;
  logic [1:0]  phase_r;           // sequencing step for the divider and square root states
  logic [47:0] dnum_r, dden_r;
  logic        lim_l_r, lim_r_r;
  logic signed [14:0] st_r;
  logic [15:0] thr_out_r;
  logic [13:0] steer_out_r;
  logic [4:0]  flags_r;
  logic        ovalid_r;

  rtsm_pkg::seq_ctl_t div_ctl, sq_ctl;
  logic        div_done, sq_done;
  logic [47:0] div_q, sq_rad;
  logic [23:0] sq_root;
  logic        div_go, sq_go;

  assign div_ctl = '{start: div_go, busy: 1'b0};
  assign sq_ctl  = '{start: sq_go, busy: 1'b0};

  rtsm_divider #(.W(48)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .num(dnum_r), .den(dden_r),
    .done(div_done), .quo(div_q)
  );
  rtsm_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .rad(sq_rad), .done(sq_done), .root(sq_root)
  );

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, steer_out_r, thr_out_r};
  assign out_tuser  = flags_r;

  // Combinational helpers.
  logic signed [16:0] speed_abs;
  logic signed [20:0] step_s, lo_s, hi_s, thr_c;
  logic [15:0] mn;
  logic signed [10:0] e_a;
  logic signed [47:0] rad_s, num_s;
  logic [15:0] mag_sat;
  logic signed [16:0] tout_s;
  logic [31:0] since;
  logic opposite;
  logic signed [14:0] smax_s;
  logic signed [16:0] tmax_s;

  assign speed_abs = speed_r[15] ? -17'(speed_r) : 17'(speed_r);
  // The slew step reaches about 268000 at the widest settings.
  assign step_s = 21'(div_q[19:0]);
  assign lo_s   = 21'(prev_r) - step_s;
  assign hi_s   = 21'(prev_r) + step_s;
  assign mn     = (tmin_r > 15'd25600) ? 16'd25600 : {1'b0, tmin_r};
  assign e_a    = 11'(expo_r) - 11'sd256;
  assign mag_sat = (mag_r > 16'd25600) ? 16'd25600 : mag_r;
  assign tout_s = neg_r ? -17'(mag_sat) : 17'(mag_sat);
  assign since  = now_r - lot_r;
  assign opposite = (tout_s < 0 && lnz_r > 0) || (tout_s > 0 && lnz_r < 0);
  // Limits as signed values so that negative steering and throttle compare correctly.
  assign smax_s = signed'({2'b00, smax_r});
  assign tmax_s = signed'({2'b00, tmax_r});

  always_comb begin
    thr_c = 21'(thr_in_r);
    if (thr_c < lo_s) thr_c = lo_s;
    if (thr_c > hi_s) thr_c = hi_s;
  end

  // 25*a*a + e*mag; a*a registered in acc_r first.
  assign rad_s = 48'sd25 * acc_r + 48'(expo_r) * 48'(signed'({1'b0, mag_r}));
  assign num_s = 48'sd10 * (48'sd1280 * 48'(e_a) + 48'(sq_root));
  assign sq_rad = (acc_r < 0) ? 48'd0 : {acc_r[31:0], 16'd0};

  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    sq_go  <= 1'b0;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      prev_r   <= '0;
      lnz_r    <= '0;
      lot_r    <= '0;
      phase_r  <= '0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          thr_in_r <= in_tdata[15:0];
          steer_r  <= in_tdata[29:16];
          speed_r  <= in_tdata[45:30];
          dt_r     <= in_tdata[55:46];
          now_r    <= in_tdata[87:56];
          armed_r  <= in_tuser;
          dnum_r   <= 48'(slew_r) * 48'(dt_r) ;
          phase_r  <= '0;
          state_r  <= S_SLEW;
        end
        S_SLEW: begin
          // Step = slew*dt*256/1000 on the divider.
          if (slew_r == 10'd0) begin
            thr_r <= 17'(thr_in_r);
            prev_r <= 17'(thr_in_r);
            state_r <= S_STEER;
            phase_r <= '0;
          end else if (phase_r == 2'd0) begin
            dnum_r  <= {20'd0, 20'(slew_r) * 20'(dt_r), 8'd0};
            dden_r  <= 48'd1000;
            div_go  <= 1'b1;
            phase_r <= 2'd1;
          end else if (phase_r == 2'd1) begin
            phase_r <= 2'd2;
          end else if (div_done) begin
            thr_r   <= 17'(thr_c);
            prev_r  <= 17'(thr_c);
            phase_r <= '0;
            state_r <= S_STEER;
          end
        end
        S_STEER: begin
          st_r <= 15'(steer_r);
          lim_l_r <= 1'b0;
          lim_r_r <= 1'b0;
          if (!armed_r) begin
            thr_out_r <= '0;
            state_r <= S_OUT;
          end else if (!scal_r) begin
            if (thr_r < 0) st_r <= -15'(steer_r);
            state_r <= S_MIN;
          end else if (base_r != 15'd0 && speed_abs > 17'(base_r)) begin
            if (phase_r == 2'd0) begin
              dnum_r  <= 48'(steer_r[13] ? -15'(steer_r) : 15'(steer_r)) * 48'(base_r);
              dden_r  <= 48'(speed_abs);
              div_go  <= 1'b1;
              phase_r <= 2'd1;
            end else if (phase_r == 2'd1) begin
              phase_r <= 2'd2;
            end else if (div_done) begin
              // Quotient sign is steer sign, flipped again when reversing.
              st_r <= (steer_r[13] ^ speed_r[15]) ? -15'(div_q[14:0]) : 15'(div_q[14:0]);
              phase_r <= '0;
              state_r <= S_MIN;
            end
          end else begin
            lim_l_r <= 1'b1;
            lim_r_r <= 1'b1;
            if (speed_r[15]) st_r <= -15'(steer_r);
            state_r <= S_MIN;
          end
        end
        S_MIN: begin
          neg_r <= thr_r < 0;
          mag_r <= thr_r[16] ? 16'(-thr_r) : 16'(thr_r);
          dnum_r <= 48'(thr_r[16] ? 16'(-thr_r) : 16'(thr_r)) * 48'(16'd25600 - mn);
          dden_r <= 48'd25600;
          if (thr_r == 0) begin
            mag_r <= '0;
            state_r <= S_HOLD;
          end else if (mn != 16'd0) begin
            div_go  <= 1'b1;
            phase_r <= 2'd1;
            state_r <= S_MINW;
          end else begin
            state_r <= S_RAD;
          end
        end
        S_MINW: begin
          if (phase_r == 2'd1) phase_r <= 2'd2;
          else if (div_done) begin
            mag_r   <= mn + div_q[15:0];
            phase_r <= '0;
            state_r <= S_RAD;
          end
        end
        S_RAD: begin
          if (expo_r == 10'sd0) begin
            state_r <= S_HOLD;
          end else if (phase_r == 2'd0) begin
            if (mag_r > 16'd25600) mag_r <= 16'd25600;
            acc_r   <= 48'(e_a) * 48'(e_a);
            phase_r <= 2'd1;
          end else if (phase_r == 2'd1) begin
            acc_r   <= rad_s;
            phase_r <= 2'd2;
          end else begin
            sq_go   <= 1'b1;
            phase_r <= 2'd3;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (phase_r == 2'd3) phase_r <= 2'd0;
          else if (sq_done) begin
            acc_r   <= num_s;
            state_r <= S_CDIV;
          end
        end
        S_CDIV: begin
          // Truncating signed division by expo via magnitudes.
          cneg_r  <= acc_r[47] ^ expo_r[9];
          dnum_r  <= acc_r[47] ? 48'(-acc_r) : 48'(acc_r);
          dden_r  <= expo_r[9] ? 48'(-48'(expo_r)) : 48'(expo_r);
          div_go  <= 1'b1;
          phase_r <= 2'd1;
          state_r <= S_CDIVW;
        end
        S_CDIVW: begin
          if (phase_r == 2'd1) phase_r <= 2'd2;
          else if (div_done) begin
            phase_r <= '0;
            if (cneg_r || div_q == 48'd0) mag_r <= '0;
            else if (div_q > 48'd25600) mag_r <= 16'd25600;
            else mag_r <= div_q[15:0];
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          thr_out_r <= 16'(tout_s);
          if (rdly_r != 14'd0 && tout_s != 0) begin
            if (opposite && since < 32'(rdly_r)) thr_out_r <= '0;
            else begin
              lot_r <= now_r;
              lnz_r <= tout_s;
            end
          end
          state_r <= S_OUT;
        end
        default: begin
          ovalid_r <= 1'b1;
          steer_out_r <= (st_r > smax_s) ? 14'(smax_s) :
                         (st_r < -smax_s) ? 14'(-smax_s) : 14'(st_r);
          flags_r <= {thr_r >= tmax_s, thr_r <= -tmax_s,
                      lim_r_r || (st_r >= smax_s),
                      lim_l_r || (st_r <= -smax_s), !armed_r};
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/rtsm_checker.sv
// Port-level checker for the rover mixer, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module rtsm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [4:0]  out_tuser
);
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_disarm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[15:0] == 16'd0)
    else $error("disarmed throttle nonzero");
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("result too early");
endmodule

bind rover_throttle_steer_mixer rtsm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
